@@ src/lbs_pkg.sv @@
package lbs_pkg;

	// Jittered up vector in Q1.14 and 1/pi in Q0.16
	localparam int LBS_UP_X = 56;
	localparam int LBS_UP_Y = 16384;
	localparam int LBS_UP_Z = 116;
	localparam int LBS_INV_PI = 20861;

	// Normalizer stage map: magnitude, squares, sum, root steps, divide prep,
	// quotient steps, sign
	localparam int LBS_SQRT_FIRST = 3;
	localparam int LBS_SQRT_STEPS = 32;
	localparam int LBS_DIV_PREP = LBS_SQRT_FIRST + LBS_SQRT_STEPS;
	localparam int LBS_DIV_FIRST = LBS_DIV_PREP + 1;
	localparam int LBS_DIV_STEPS = 15;
	localparam int LBS_NORM_STAGES = LBS_DIV_FIRST + LBS_DIV_STEPS + 1;
	localparam int LBS_FRAME_STAGES = 4;
	localparam int LBS_SHADE_STAGES = 4;

	typedef enum logic [1:0] {
		LBS_REG_GAIN  = 2'd0,
		LBS_REG_RED   = 2'd1,
		LBS_REG_GREEN = 2'd2,
		LBS_REG_BLUE  = 2'd3
	} lbs_reg_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic [14:0] sample_z;
	} lbs_in_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [14:0] density;
		logic [15:0] brdf_red;
		logic [15:0] brdf_green;
		logic [15:0] brdf_blue;
		logic [15:0] reflect_red;
		logic [15:0] reflect_green;
		logic [15:0] reflect_blue;
	} lbs_out_t;

	// Wide vector (two's complement components) and unit direction in Q1.14
	typedef logic [2:0][33:0] lbs_vec_t;
	typedef logic [2:0][15:0] lbs_dir_t;

	// Per-transaction data carried alongside the vector math
	typedef struct packed {
		logic [2:0][15:0] n;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [14:0] sz;
	} lbs_side_t;

endpackage

@@ src/lambertian_brdf_sample_unit.sv @@
// Lambertian cosine-weighted hemisphere sampler.
// Input channel item/item_valid/item_ready carries a unit normal and a sample
// point (Q1.14). Output channel result/result_valid/result_ready returns the
// normalized incident direction, cosine/pi density and the diffuse and
// reflectance values. Both channels transfer a transaction when valid and
// ready are high at a rising clock edge.
// The configuration port (write_en, reg_index, write_data) sets gain and color;
// write only while no transaction is in flight. Color terms follow a write
// through the color, product and output registers.
// The pipeline has one cross product stage, two normalizers of 52 stages each
// (32 square root steps, 15 quotient steps), four basis stages and four density
// stages. Throughput is one transaction per cycle while result_ready is high.
// When result_ready is low the last stage holds; earlier stages keep filling
// empty slots, so item_ready drops only once the whole pipeline is full.
// Reset clears all stage valid bits and sets the gain and color registers to zero.
module lambertian_brdf_sample_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  lbs_pkg::lbs_in_t      item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output lbs_pkg::lbs_out_t     result,
	input  logic                  write_en,
	input  logic [1:0]            reg_index,
	input  logic [15:0]           write_data
);

	logic                vld_s1;
	lbs_pkg::lbs_vec_t   vec_s1;
	lbs_pkg::lbs_side_t  side_s1;
	lbs_pkg::lbs_side_t  side_in;
	lbs_pkg::lbs_vec_t   upx;
	logic                go_s1;

	logic                n1_ready, n1_valid;
	lbs_pkg::lbs_dir_t   n1_dir;
	lbs_pkg::lbs_side_t  n1_side;
	logic                fr_ready, fr_valid;
	lbs_pkg::lbs_vec_t   fr_w;
	lbs_pkg::lbs_side_t  fr_side;
	logic                n2_ready, n2_valid;
	lbs_pkg::lbs_dir_t   n2_dir;
	lbs_pkg::lbs_side_t  n2_side;
	logic                sh_ready;

	// Pack the input transaction for the side channel
	always_comb begin
		side_in.n[0] = item.normal_x;
		side_in.n[1] = item.normal_y;
		side_in.n[2] = item.normal_z;
		side_in.sx = item.sample_x;
		side_in.sy = item.sample_y;
		side_in.sz = item.sample_z;
	end

	// Up vector cross normal, exact in Q2.28
	always_comb begin
		upx[0] = 34'(34'(lbs_pkg::LBS_UP_Y) * $signed(item.normal_z) -
			34'(lbs_pkg::LBS_UP_Z) * $signed(item.normal_y));
		upx[1] = 34'(34'(lbs_pkg::LBS_UP_Z) * $signed(item.normal_x) -
			34'(lbs_pkg::LBS_UP_X) * $signed(item.normal_z));
		upx[2] = 34'(34'(lbs_pkg::LBS_UP_X) * $signed(item.normal_y) -
			34'(lbs_pkg::LBS_UP_Y) * $signed(item.normal_x));
	end

	assign go_s1 = !vld_s1 || n1_ready;
	assign item_ready = go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (go_s1)
			vld_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			vec_s1 <= upx;
			side_s1 <= side_in;
		end
	end

	lbs_norm u_norm_v (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (n1_ready),
		.in_vec    (vec_s1),
		.in_side   (side_s1),
		.out_valid (n1_valid),
		.out_ready (fr_ready),
		.out_dir   (n1_dir),
		.out_side  (n1_side)
	);

	lbs_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (n1_valid),
		.in_ready  (fr_ready),
		.in_v      (n1_dir),
		.in_side   (n1_side),
		.out_valid (fr_valid),
		.out_ready (n2_ready),
		.out_w     (fr_w),
		.out_side  (fr_side)
	);

	lbs_norm u_norm_wi (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (n2_ready),
		.in_vec    (fr_w),
		.in_side   (fr_side),
		.out_valid (n2_valid),
		.out_ready (sh_ready),
		.out_dir   (n2_dir),
		.out_side  (n2_side)
	);

	lbs_shade u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.in_valid   (n2_valid),
		.in_ready   (sh_ready),
		.in_d       (n2_dir),
		.in_side    (n2_side),
		.out_valid  (result_valid),
		.out_ready  (result_ready),
		.out_data   (result)
	);

endmodule

@@ src/lbs_norm.sv @@
module lbs_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lbs_pkg::lbs_vec_t     in_vec,
	input  lbs_pkg::lbs_side_t    in_side,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lbs_pkg::lbs_dir_t     out_dir,
	output lbs_pkg::lbs_side_t    out_side
);

	typedef struct packed {
		logic [2:0]        sgn;
		logic [2:0][30:0]  m;
		logic [2:0][61:0]  sq;
		logic [63:0]       acc;
		logic [63:0]       root;
		logic [31:0]       len;
		logic              lz;
		logic [2:0][46:0]  rem;
		logic [2:0][14:0]  q;
		lbs_pkg::lbs_dir_t dir;
		lbs_pkg::lbs_side_t side;
	} norm_rec_t;

	// Take magnitudes and scale them together below 2^31
	function automatic norm_rec_t norm_load(input lbs_pkg::lbs_vec_t v,
		input lbs_pkg::lbs_side_t s);
		norm_rec_t r;
		logic [2:0][33:0] mag;
		logic [33:0] orv;
		logic [33:0] tmp;
		logic [1:0] sh;
		r = '0;
		r.side = s;
		for (int i = 0; i < 3; i++) begin
			r.sgn[i] = v[i][33];
			mag[i] = v[i][33] ? 34'(~v[i] + 34'd1) : v[i];
		end
		orv = mag[0] | mag[1] | mag[2];
		if (orv[33])
			sh = 2'd3;
		else if (orv[32])
			sh = 2'd2;
		else if (orv[31])
			sh = 2'd1;
		else
			sh = 2'd0;
		for (int i = 0; i < 3; i++) begin
			tmp = mag[i] >> sh;
			r.m[i] = tmp[30:0];
		end
		return r;
	endfunction

	function automatic norm_rec_t norm_step(input int k, input norm_rec_t p);
		norm_rec_t r;
		logic [63:0] pw;
		logic [63:0] trial;
		logic [46:0] dv;
		logic [14:0] qq;
		r = p;
		if (k == 1) begin
			for (int i = 0; i < 3; i++)
				r.sq[i] = 62'(p.m[i]) * 62'(p.m[i]);
		end else if (k == 2) begin
			r.acc = 64'(p.sq[0]) + 64'(p.sq[1]) + 64'(p.sq[2]);
			r.root = '0;
		end else if (k >= lbs_pkg::LBS_SQRT_FIRST && k < lbs_pkg::LBS_DIV_PREP) begin
			// One bit pair of the integer square root
			pw = 64'd1 << (62 - 2 * (k - lbs_pkg::LBS_SQRT_FIRST));
			trial = p.root + pw;
			if (p.acc >= trial) begin
				r.acc = p.acc - trial;
				r.root = (p.root >> 1) + pw;
			end else begin
				r.root = p.root >> 1;
			end
		end else if (k == lbs_pkg::LBS_DIV_PREP) begin
			r.len = p.root[31:0];
			r.lz = (p.root[31:0] == 32'd0);
			for (int i = 0; i < 3; i++) begin
				r.rem[i] = {2'b00, p.m[i], 14'd0} + 47'(p.root[31:1]);
				r.q[i] = '0;
			end
		end else if (k >= lbs_pkg::LBS_DIV_FIRST &&
				k < lbs_pkg::LBS_DIV_FIRST + lbs_pkg::LBS_DIV_STEPS) begin
			// One restoring quotient bit, most significant first
			dv = 47'(p.len) << (lbs_pkg::LBS_DIV_STEPS - 1 - (k - lbs_pkg::LBS_DIV_FIRST));
			for (int i = 0; i < 3; i++) begin
				if (p.rem[i] >= dv) begin
					r.rem[i] = p.rem[i] - dv;
					r.q[i] = p.q[i] | (15'd1 << (lbs_pkg::LBS_DIV_STEPS - 1 -
						(k - lbs_pkg::LBS_DIV_FIRST)));
				end
			end
		end else if (k == lbs_pkg::LBS_NORM_STAGES - 1) begin
			// Zero length gives zero; clamp to unit and restore sign
			for (int i = 0; i < 3; i++) begin
				if (p.lz)
					qq = '0;
				else if (p.q[i] > 15'd16384)
					qq = 15'd16384;
				else
					qq = p.q[i];
				r.dir[i] = p.sgn[i] ? 16'(~{1'b0, qq} + 16'd1) : {1'b0, qq};
			end
		end
		return r;
	endfunction

	norm_rec_t rec_s [lbs_pkg::LBS_NORM_STAGES];
	logic [lbs_pkg::LBS_NORM_STAGES-1:0] vld_s;
	logic [lbs_pkg::LBS_NORM_STAGES-1:0] go;

	// Stage may load when empty or when its content moves on
	for (genvar g = 0; g < lbs_pkg::LBS_NORM_STAGES; g++) begin : g_stage
		if (g == lbs_pkg::LBS_NORM_STAGES - 1) begin : g_last
			assign go[g] = !vld_s[g] || out_ready;
		end else begin : g_mid
			assign go[g] = !vld_s[g] || go[g+1];
		end

		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[g] <= 1'b0;
				else if (go[g])
					vld_s[g] <= in_valid;
			end
			always_ff @(posedge clk) begin
				if (go[g])
					rec_s[g] <= norm_load(in_vec, in_side);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[g] <= 1'b0;
				else if (go[g])
					vld_s[g] <= vld_s[g-1];
			end
			always_ff @(posedge clk) begin
				if (go[g])
					rec_s[g] <= norm_step(g, rec_s[g-1]);
			end
		end
	end

	assign in_ready = go[0];
	assign out_valid = vld_s[lbs_pkg::LBS_NORM_STAGES-1];
	assign out_dir = rec_s[lbs_pkg::LBS_NORM_STAGES-1].dir;
	assign out_side = rec_s[lbs_pkg::LBS_NORM_STAGES-1].side;

endmodule

@@ src/lbs_frame.sv @@
module lbs_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lbs_pkg::lbs_dir_t     in_v,
	input  lbs_pkg::lbs_side_t    in_side,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lbs_pkg::lbs_vec_t     out_w,
	output lbs_pkg::lbs_side_t    out_side
);

	typedef struct packed {
		logic [5:0][31:0]  xp;
		logic [2:0][17:0]  u;
		logic [2:0][33:0]  pu;
		logic [2:0][31:0]  pv;
		logic [2:0][31:0]  pn;
		lbs_pkg::lbs_vec_t w;
		lbs_pkg::lbs_dir_t v;
		lbs_pkg::lbs_side_t side;
	} frame_rec_t;

	// Round a Q.28 value half away from zero to Q.14
	function automatic logic [17:0] rnd14(input logic [32:0] t);
		logic [32:0] mag;
		logic [32:0] mr;
		mag = t[32] ? 33'(~t + 33'd1) : t;
		mr = (mag + 33'd8192) >> 14;
		return t[32] ? 18'(~mr + 33'd1) : mr[17:0];
	endfunction

	// Partial products of v x n
	function automatic frame_rec_t frame_load(input lbs_pkg::lbs_dir_t v,
		input lbs_pkg::lbs_side_t s);
		frame_rec_t r;
		r = '0;
		r.v = v;
		r.side = s;
		r.xp[0] = 32'($signed(v[1]) * $signed(s.n[2]));
		r.xp[1] = 32'($signed(v[2]) * $signed(s.n[1]));
		r.xp[2] = 32'($signed(v[2]) * $signed(s.n[0]));
		r.xp[3] = 32'($signed(v[0]) * $signed(s.n[2]));
		r.xp[4] = 32'($signed(v[0]) * $signed(s.n[1]));
		r.xp[5] = 32'($signed(v[1]) * $signed(s.n[0]));
		return r;
	endfunction

	function automatic frame_rec_t frame_step(input int k, input frame_rec_t p);
		frame_rec_t r;
		r = p;
		if (k == 1) begin
			for (int i = 0; i < 3; i++)
				r.u[i] = rnd14(33'($signed(p.xp[2*i]) - $signed(p.xp[2*i+1])));
		end else if (k == 2) begin
			for (int i = 0; i < 3; i++) begin
				r.pu[i] = 34'($signed(p.u[i]) * $signed(p.side.sx));
				r.pv[i] = 32'($signed(p.v[i]) * $signed(p.side.sy));
				r.pn[i] = 32'($signed(p.side.n[i]) * $signed({1'b0, p.side.sz}));
			end
		end else if (k == 3) begin
			for (int i = 0; i < 3; i++)
				r.w[i] = 34'($signed(p.pu[i]) + $signed(p.pv[i]) + $signed(p.pn[i]));
		end
		return r;
	endfunction

	frame_rec_t rec_s [lbs_pkg::LBS_FRAME_STAGES];
	logic [lbs_pkg::LBS_FRAME_STAGES-1:0] vld_s;
	logic [lbs_pkg::LBS_FRAME_STAGES-1:0] go;

	// Advance each stage when empty or when downstream moves
	for (genvar g = 0; g < lbs_pkg::LBS_FRAME_STAGES; g++) begin : g_stage
		if (g == lbs_pkg::LBS_FRAME_STAGES - 1) begin : g_last
			assign go[g] = !vld_s[g] || out_ready;
		end else begin : g_mid
			assign go[g] = !vld_s[g] || go[g+1];
		end

		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[g] <= 1'b0;
				else if (go[g])
					vld_s[g] <= in_valid;
			end
			always_ff @(posedge clk) begin
				if (go[g])
					rec_s[g] <= frame_load(in_v, in_side);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[g] <= 1'b0;
				else if (go[g])
					vld_s[g] <= vld_s[g-1];
			end
			always_ff @(posedge clk) begin
				if (go[g])
					rec_s[g] <= frame_step(g, rec_s[g-1]);
			end
		end
	end

	assign in_ready = go[0];
	assign out_valid = vld_s[lbs_pkg::LBS_FRAME_STAGES-1];
	assign out_w = rec_s[lbs_pkg::LBS_FRAME_STAGES-1].w;
	assign out_side = rec_s[lbs_pkg::LBS_FRAME_STAGES-1].side;

endmodule

@@ src/lbs_shade.sv @@
module lbs_shade (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  write_en,
	input  logic [1:0]            reg_index,
	input  logic [15:0]           write_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lbs_pkg::lbs_dir_t     in_d,
	input  lbs_pkg::lbs_side_t    in_side,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lbs_pkg::lbs_out_t     out_data
);

	typedef struct packed {
		logic [2:0][31:0]  pd;
		logic [33:0]       dot;
		logic [46:0]       pr;
		logic [14:0]       dens;
		lbs_pkg::lbs_dir_t d;
	} shade_rec_t;

	function automatic shade_rec_t shade_load(input lbs_pkg::lbs_dir_t d,
		input lbs_pkg::lbs_side_t s);
		shade_rec_t r;
		r = '0;
		r.d = d;
		for (int i = 0; i < 3; i++)
			r.pd[i] = 32'($signed(s.n[i]) * $signed(d[i]));
		return r;
	endfunction

	function automatic shade_rec_t shade_step(input int k, input shade_rec_t p);
		shade_rec_t r;
		logic [18:0] tmp;
		r = p;
		if (k == 1) begin
			r.dot = 34'($signed(p.pd[0]) + $signed(p.pd[1]) + $signed(p.pd[2]));
		end else if (k == 2) begin
			// Back-facing gives zero density
			if (!p.dot[33] && p.dot != 34'd0)
				r.pr = 47'(p.dot[30:0]) * 47'(lbs_pkg::LBS_INV_PI);
			else
				r.pr = '0;
		end else if (k == 3) begin
			tmp = 19'((p.pr + 47'd134217728) >> 28);
			r.dens = (tmp > 19'd32767) ? 15'h7fff : tmp[14:0];
		end
		return r;
	endfunction

	logic [15:0] gain_q;
	logic [2:0][15:0] color_q;
	logic [2:0][31:0] prod_q;
	logic [2:0][15:0] brdf_q;
	logic [2:0][15:0] refl_q;
	logic [16:0] brdf_raw [3];
	logic [16:0] refl_raw [3];

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			color_q <= '0;
		end else if (write_en) begin
			unique case (lbs_pkg::lbs_reg_t'(reg_index))
				lbs_pkg::LBS_REG_GAIN:  gain_q <= write_data;
				lbs_pkg::LBS_REG_RED:   color_q[0] <= write_data;
				lbs_pkg::LBS_REG_GREEN: color_q[1] <= write_data;
				lbs_pkg::LBS_REG_BLUE:  color_q[2] <= write_data;
			endcase
		end
	end

	// Scale color by gain, BRDF also by 1/pi; round, saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			brdf_raw[i] = 17'((48'(prod_q[i]) * 48'(lbs_pkg::LBS_INV_PI) +
				48'd1073741824) >> 31);
			refl_raw[i] = 17'((33'(prod_q[i]) + 33'd32768) >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
			brdf_q <= '0;
			refl_q <= '0;
		end else begin
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= 32'(color_q[i]) * 32'(gain_q);
				brdf_q[i] <= brdf_raw[i][16] ? 16'hffff : brdf_raw[i][15:0];
				refl_q[i] <= refl_raw[i][16] ? 16'hffff : refl_raw[i][15:0];
			end
		end
	end

	shade_rec_t rec_s [lbs_pkg::LBS_SHADE_STAGES];
	logic [lbs_pkg::LBS_SHADE_STAGES-1:0] vld_s;
	logic [lbs_pkg::LBS_SHADE_STAGES-1:0] go;

	// Advance each stage when empty or when downstream moves
	for (genvar g = 0; g < lbs_pkg::LBS_SHADE_STAGES; g++) begin : g_stage
		if (g == lbs_pkg::LBS_SHADE_STAGES - 1) begin : g_last
			assign go[g] = !vld_s[g] || out_ready;
		end else begin : g_mid
			assign go[g] = !vld_s[g] || go[g+1];
		end

		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[g] <= 1'b0;
				else if (go[g])
					vld_s[g] <= in_valid;
			end
			always_ff @(posedge clk) begin
				if (go[g])
					rec_s[g] <= shade_load(in_d, in_side);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[g] <= 1'b0;
				else if (go[g])
					vld_s[g] <= vld_s[g-1];
			end
			always_ff @(posedge clk) begin
				if (go[g])
					rec_s[g] <= shade_step(g, rec_s[g-1]);
			end
		end
	end

	// Assemble the result transaction from the last stage
	always_comb begin
		out_data.dir_x = rec_s[lbs_pkg::LBS_SHADE_STAGES-1].d[0];
		out_data.dir_y = rec_s[lbs_pkg::LBS_SHADE_STAGES-1].d[1];
		out_data.dir_z = rec_s[lbs_pkg::LBS_SHADE_STAGES-1].d[2];
		out_data.density = rec_s[lbs_pkg::LBS_SHADE_STAGES-1].dens;
		out_data.brdf_red = brdf_q[0];
		out_data.brdf_green = brdf_q[1];
		out_data.brdf_blue = brdf_q[2];
		out_data.reflect_red = refl_q[0];
		out_data.reflect_green = refl_q[1];
		out_data.reflect_blue = refl_q[2];
	end

	assign in_ready = go[0];
	assign out_valid = vld_s[lbs_pkg::LBS_SHADE_STAGES-1];

endmodule

@@ sim/tb_lambertian_brdf_sample_unit.sv @@
module tb_lambertian_brdf_sample_unit;

	localparam int PIPE_LATENCY = 113;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	lbs_pkg::lbs_in_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	lbs_pkg::lbs_out_t result;
	logic write_en = 1'b0;
	logic [1:0] reg_index = '0;
	logic [15:0] write_data = '0;

	// Shadow copy of the shading registers
	logic [15:0] gain_q, red_q, green_q, blue_q;

	lbs_pkg::lbs_out_t sample_queue[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit stall_free = 1'b0;

	lambertian_brdf_sample_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.write_en(write_en), .reg_index(reg_index), .write_data(write_data)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned mag_of(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint round_q14(longint v);
		longint unsigned m;
		m = (mag_of(v) + 8192) >> 14;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Scale a wide vector to unit length in Q1.14; zero stays zero
	task automatic unit_vector(input longint c[3], output longint o[3]);
		longint unsigned m[3];
		longint unsigned sum, len, q;
		sum = 0;
		for (int i = 0; i < 3; i++) m[i] = mag_of(c[i]);
		while (m[0] >= 64'd2147483648 || m[1] >= 64'd2147483648 ||
			m[2] >= 64'd2147483648) begin
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		for (int i = 0; i < 3; i++) sum += m[i] * m[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = 0;
			if (len != 0) q = (m[i] * 16384 + len / 2) / len;
			if (q > 16384) q = 16384;
			o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
		end
	endtask

	task automatic cross_prod(input longint a[3], input longint b[3], output longint o[3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endtask

	// Work out the shading result of one sample
	task automatic shade_sample(input lbs_pkg::lbs_in_t s, output lbs_pkg::lbs_out_t r);
		longint up[3], n[3], v[3], u[3], t[3], w[3], d[3];
		longint sx, sy, sz, dot;
		longint unsigned dens, p, b, rf;
		logic [15:0] col[3];
		logic [15:0] brdf[3], refl[3];
		up[0] = lbs_pkg::LBS_UP_X; up[1] = lbs_pkg::LBS_UP_Y; up[2] = lbs_pkg::LBS_UP_Z;
		n[0] = s.normal_x; n[1] = s.normal_y; n[2] = s.normal_z;
		sx = s.sample_x; sy = s.sample_y; sz = longint'({1'b0, s.sample_z});
		cross_prod(up, n, t);
		unit_vector(t, v);
		cross_prod(v, n, t);
		for (int i = 0; i < 3; i++) u[i] = round_q14(t[i]);
		for (int i = 0; i < 3; i++) w[i] = u[i] * sx + v[i] * sy + n[i] * sz;
		unit_vector(w, d);
		dot = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
		dens = 0;
		if (dot > 0) begin
			dens = (longint'(dot) * lbs_pkg::LBS_INV_PI + (64'd1 << 27)) >> 28;
			if (dens > 32767) dens = 32767;
		end
		col[0] = red_q; col[1] = green_q; col[2] = blue_q;
		for (int i = 0; i < 3; i++) begin
			p = longint'(col[i]) * longint'(gain_q);
			b = (p * lbs_pkg::LBS_INV_PI + (64'd1 << 30)) >> 31;
			rf = (p + 32768) >> 16;
			brdf[i] = (b > 65535) ? 16'hFFFF : b[15:0];
			refl[i] = (rf > 65535) ? 16'hFFFF : rf[15:0];
		end
		r.dir_x = d[0][15:0];
		r.dir_y = d[1][15:0];
		r.dir_z = d[2][15:0];
		r.density = dens[14:0];
		r.brdf_red = brdf[0]; r.brdf_green = brdf[1]; r.brdf_blue = brdf[2];
		r.reflect_red = refl[0]; r.reflect_green = refl[1]; r.reflect_blue = refl[2];
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	function automatic int gap_len();
		if (stall_free) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, 3);
	endfunction

	// Drive one sample and hold it until the transaction completes
	task automatic send_sample(input lbs_pkg::lbs_in_t s);
		lbs_pkg::lbs_out_t r;
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= s;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		shade_sample(s, r);
		sample_queue.push_back(r);
		@(negedge clk);
	endtask

	task automatic write_reg(input lbs_pkg::lbs_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		write_en <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		@(negedge clk);
		write_en <= 1'b0;
		case (idx)
			lbs_pkg::LBS_REG_GAIN:  gain_q = val;
			lbs_pkg::LBS_REG_RED:   red_q = val;
			lbs_pkg::LBS_REG_GREEN: green_q = val;
			lbs_pkg::LBS_REG_BLUE:  blue_q = val;
		endcase
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain_wait();
		item_valid <= 1'b0;
		wait (sample_queue.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_shading(input logic [15:0] g, input logic [15:0] r,
		input logic [15:0] gr, input logic [15:0] b);
		drain_wait();
		write_reg(lbs_pkg::LBS_REG_GAIN, g);
		write_reg(lbs_pkg::LBS_REG_RED, r);
		write_reg(lbs_pkg::LBS_REG_GREEN, gr);
		write_reg(lbs_pkg::LBS_REG_BLUE, b);
		repeat (3) @(negedge clk);
	endtask

	function automatic lbs_pkg::lbs_in_t make_sample(input logic [15:0] nx,
		input logic [15:0] ny, input logic [15:0] nz, input logic [15:0] sx,
		input logic [15:0] sy, input logic [14:0] sz);
		lbs_pkg::lbs_in_t s;
		s.normal_x = nx; s.normal_y = ny; s.normal_z = nz;
		s.sample_x = sx; s.sample_y = sy; s.sample_z = sz;
		return s;
	endfunction

	// Mostly a random unit hemisphere point and roughly unit normal
	function automatic lbs_pkg::lbs_in_t rand_sample();
		lbs_pkg::lbs_in_t s;
		real a, b, c, l, ph, ct, st;
		if ($urandom_range(0, 9) == 0) begin
			s = make_sample(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 15'($urandom));
			return s;
		end
		do begin
			a = $urandom_range(0, 2000) - 1000.0;
			b = $urandom_range(0, 2000) - 1000.0;
			c = $urandom_range(0, 2000) - 1000.0;
			l = $sqrt(a * a + b * b + c * c);
		end while (l < 10.0);
		ph = $urandom_range(0, 62831) / 10000.0;
		ct = $sqrt($urandom_range(0, 10000) / 10000.0);
		st = $sqrt(1.0 - ct * ct);
		s.normal_x = 16'($rtoi(a / l * 16384.0));
		s.normal_y = 16'($rtoi(b / l * 16384.0));
		s.normal_z = 16'($rtoi(c / l * 16384.0));
		s.sample_x = 16'($rtoi(st * $cos(ph) * 16384.0));
		s.sample_y = 16'($rtoi(st * $sin(ph) * 16384.0));
		s.sample_z = 15'($rtoi(ct * 16384.0));
		return s;
	endfunction

	task automatic test_directed();
		send_sample(make_sample(16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 15'd16384));
		send_sample(make_sample(16'd56, 16'd16384, 16'd116, 16'd5000, 16'd3000, 15'd9000));
		send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd100, 16'd200, 15'd300));
		send_sample(make_sample(16'd0, 16'd0, 16'd16384, 16'd16384, 16'd0, 15'd0));
		send_sample(make_sample(16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 15'd16384));
		send_sample(make_sample(16'd16384, 16'd0, 16'd0, -16'sd16384, 16'd0, 15'd0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 15'd16384));
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'h7FFF));
		send_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF));
		send_sample(make_sample(16'd0, -16'sd16384, 16'd0, 16'd0, -16'sd16384, 15'd0));
		send_sample(make_sample(16'd9459, 16'd9459, 16'd9459, 16'd0, 16'd16384, 15'd0));
		send_sample(make_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0));
		send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF));
	endtask

	task automatic test_random_block(input int count);
		for (int i = 0; i < count; i++) send_sample(rand_sample());
	endtask

	// Hold the sender until fully drained, then send 20 random samples
	task automatic test_drain_pause();
		drain_wait();
		test_random_block(20);
	endtask

	task automatic test_back_to_back();
		stall_free = 1'b1;
		test_random_block(300);
		stall_free = 1'b0;
	endtask

	// Compare each completed transaction against the oldest expectation
	always @(posedge clk) begin
		lbs_pkg::lbs_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (sample_queue.size() == 0) begin
				report_mismatch("unexpected result transaction", 1, 0);
			end else begin
				want = sample_queue.pop_front();
				if (result.dir_x !== want.dir_x) report_mismatch("dir_x", result.dir_x, want.dir_x);
				if (result.dir_y !== want.dir_y) report_mismatch("dir_y", result.dir_y, want.dir_y);
				if (result.dir_z !== want.dir_z) report_mismatch("dir_z", result.dir_z, want.dir_z);
				if (result.density !== want.density)
					report_mismatch("density", result.density, want.density);
				if (result.brdf_red !== want.brdf_red)
					report_mismatch("brdf_red", result.brdf_red, want.brdf_red);
				if (result.brdf_green !== want.brdf_green)
					report_mismatch("brdf_green", result.brdf_green, want.brdf_green);
				if (result.brdf_blue !== want.brdf_blue)
					report_mismatch("brdf_blue", result.brdf_blue, want.brdf_blue);
				if (result.reflect_red !== want.reflect_red)
					report_mismatch("reflect_red", result.reflect_red, want.reflect_red);
				if (result.reflect_green !== want.reflect_green)
					report_mismatch("reflect_green", result.reflect_green, want.reflect_green);
				if (result.reflect_blue !== want.reflect_blue)
					report_mismatch("reflect_blue", result.reflect_blue, want.reflect_blue);
			end
		end
	end

	// Toggle result_ready with random stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			result_ready <= 1'b1;
			@(negedge clk);
			gap = gap_len();
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	// Advance the watchdog while no transaction moves
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		gain_q = '0; red_q = '0; green_q = '0; blue_q = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		set_shading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		test_directed();
		set_shading(16'h8000, 16'h1234, 16'hABCD, 16'h0001);
		test_random_block(400);
		test_drain_pause();
		for (int k = 0; k < 4; k++) begin
			set_shading(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			test_random_block(280);
		end
		set_shading(16'h0000, 16'hFFFF, 16'h0000, 16'h8000);
		test_back_to_back();
		test_random_block(80);
		drain_wait();
		repeat (PIPE_LATENCY + 20) @(negedge clk);
		if (error_count == 0 && sample_queue.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/lbs_pkg.sv
src/lbs_norm.sv
src/lbs_frame.sv
src/lbs_shade.sv
src/lambertian_brdf_sample_unit.sv
sim/tb_lambertian_brdf_sample_unit.sv
